// ===== rtl/core/trz_pkg.sv =====
// Package for the triangle rasteriser with depth buffer.
// Beat types, operation codes, fixed widths, controller/datapath bundles, helpers.
// No dependencies.
package trz_pkg;

	// Operation codes
	localparam logic [1:0] OP_VERTEX = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Fixed widths set by the beat fields
	localparam int CW    = 16;          // vertex coordinate / depth
	localparam int SW    = 18;          // setup multiplier operand
	localparam int PW    = 2 * SW;      // setup product
	localparam int EW    = 38;          // edge function accumulator
	localparam int DW    = 34;          // doubled area magnitude
	localparam int QW    = 16;          // quotient bits per division
	localparam int ACC_W = DW + QW;     // numerator / remainder-quotient register
	localparam int BW    = 14;          // signed pixel coordinate in box setup
	localparam int MEM_W = 25;          // drawn bit, grey, depth
	localparam int CMPW  = 13;          // frame size compare width

	localparam logic signed [CW-1:0] DEPTH_ONE = 16'sd16384;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [CW-1:0]    vertex_x;
		logic signed [CW-1:0]    vertex_y;
		logic signed [CW-1:0]    vertex_depth;
		logic [7:0]              vertex_grey;
		logic [6:0]              pixel_x;
		logic [6:0]              pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [31:0]             pixel_color;
		logic signed [CW-1:0]    pixel_depth;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic       latch_en;
		logic [1:0] latch_idx;
		logic       clr_start;
		logic       clr_en;
		logic       rd_req;
		logic       out_load;
		logic       box_en;
		logic       mul_en;
		logic [2:0] mul_idx;
		logic       fin_en;
		logic       pix_en;
		logic       mac_en;
		logic [3:0] bit_idx;
		logic       div_en;
		logic       wr_en;
		logic       step_en;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic d_zero;
		logic box_empty;
		logic in_tri;
		logic x_last;
		logic y_last;
	} sts_t;

	// Truncate a 4-fraction-bit coordinate toward zero to a whole pixel
	function automatic logic signed [12:0] trunc_px(input logic signed [CW-1:0] v);
		logic signed [16:0] s;
		s = 17'(v) + (v[CW-1] ? 17'sd15 : 17'sd0);
		return $signed(s[16:4]);
	endfunction

	// One restoring division step on {remainder, numerator low bits}
	function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] a,
			input logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] r;
		logic        ge;
		t  = {a[ACC_W-1:QW], a[QW-1]};
		ge = (t >= {1'b0, d});
		r  = ge ? (t - {1'b0, d}) : t;
		return {r[DW-1:0], a[QW-2:0], ge};
	endfunction

endpackage

// ===== rtl/core/trz_ctrl.sv =====
// Controller for the triangle rasteriser: sequences vertex latching, setup,
// per-pixel multiply-accumulate and division, clearing and reads. Uses trz_pkg.
module trz_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	output logic              out_valid,
	input  logic              out_ready,
	input  trz_pkg::sts_t     sts,
	output trz_pkg::cmd_t     cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_RDW   = 4'd2;
	localparam logic [3:0] S_BOX   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_FIN   = 4'd5;
	localparam logic [3:0] S_PIX   = 4'd6;
	localparam logic [3:0] S_MAC   = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_WRITE = 4'd9;
	localparam logic [3:0] S_STEP  = 4'd10;

	logic [3:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [1:0] vc_q, vc_d;
	logic       out_valid_q;
	logic       accept;
	logic [1:0] vidx;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign vidx      = (vc_q == 2'd3) ? 2'd0 : vc_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		vc_d    = vc_q;
		cmd     = '0;
		cmd.latch_idx = vidx;
		cmd.mul_idx   = cnt_q[2:0];
		cmd.bit_idx   = ~cnt_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (operation)
						trz_pkg::OP_VERTEX: begin
							cmd.latch_en = 1'b1;
							if (vidx == 2'd2) begin
								vc_d    = 2'd0;
								state_d = S_BOX;
							end else begin
								vc_d = vidx + 2'd1;
							end
						end
						trz_pkg::OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = S_CLEAR;
						end
						trz_pkg::OP_READ: begin
							cmd.rd_req = 1'b1;
							state_d    = S_RDW;
						end
						default: ;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_RDW: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_BOX: begin
				cmd.box_en = 1'b1;
				cnt_d      = '0;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (cnt_q == 4'd5) begin
					state_d = S_FIN;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			S_FIN: begin
				cmd.fin_en = 1'b1;
				state_d = (sts.d_zero || sts.box_empty) ? S_IDLE : S_PIX;
			end
			S_PIX: begin
				cmd.pix_en = 1'b1;
				cnt_d      = '0;
				state_d    = sts.in_tri ? S_MAC : S_STEP;
			end
			S_MAC: begin
				cmd.mac_en = 1'b1;
				cnt_d      = cnt_q + 4'd1;
				if (cnt_q == 4'd15) state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_en = 1'b1;
				cnt_d      = cnt_q + 4'd1;
				if (cnt_q == 4'd15) state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = S_STEP;
			end
			S_STEP: begin
				cmd.step_en = 1'b1;
				state_d = (sts.x_last && sts.y_last) ? S_IDLE : S_PIX;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State registers; reset starts with a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			vc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			vc_q    <= vc_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/trz_dp.sv =====
// Datapath for the triangle rasteriser: vertex latches, setup multiplier, edge
// walkers, serial interpolation and division, frame memory. Uses trz_pkg.
module trz_dp #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  trz_pkg::in_item_t   in_item,
	input  trz_pkg::cmd_t       cmd,
	output trz_pkg::sts_t       sts,
	output trz_pkg::out_item_t  out_item
);

	localparam int XW     = $clog2(FRAME_WIDTH);
	localparam int YW     = $clog2(FRAME_HEIGHT);
	localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW     = $clog2(PIXELS);
	localparam int EW     = trz_pkg::EW;
	localparam int DW     = trz_pkg::DW;
	localparam int SW     = trz_pkg::SW;
	localparam int PW     = trz_pkg::PW;
	localparam int BW     = trz_pkg::BW;
	localparam int ACC_W  = trz_pkg::ACC_W;
	localparam logic signed [BW-1:0] XMAX = BW'(FRAME_WIDTH - 1);
	localparam logic signed [BW-1:0] YMAX = BW'(FRAME_HEIGHT - 1);

	// Vertex latches
	logic signed [15:0] lx_q [3];
	logic signed [15:0] ly_q [3];
	logic signed [15:0] lz_q [3];
	logic [7:0]         lg_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lx_q[i] <= '0;
				ly_q[i] <= '0;
				lz_q[i] <= '0;
				lg_q[i] <= '0;
			end
		end else if (cmd.latch_en && cmd.latch_idx != 2'd3) begin
			lx_q[cmd.latch_idx] <= in_item.vertex_x;
			ly_q[cmd.latch_idx] <= in_item.vertex_y;
			lz_q[cmd.latch_idx] <= in_item.vertex_depth;
			lg_q[cmd.latch_idx] <= in_item.vertex_grey;
		end
	end

	// Bounding box, truncated and clipped
	logic signed [15:0] mnx, mxx, mny, mxy;
	logic signed [BW-1:0] bx0, bx1, by0, by1;
	logic [XW-1:0] mn_x_q, mx_x_q;
	logic [YW-1:0] mn_y_q, mx_y_q;
	logic          empty_q;

	always_comb begin
		mnx = (lx_q[0] < lx_q[1]) ? lx_q[0] : lx_q[1];
		mnx = (mnx < lx_q[2]) ? mnx : lx_q[2];
		mxx = (lx_q[0] > lx_q[1]) ? lx_q[0] : lx_q[1];
		mxx = (mxx > lx_q[2]) ? mxx : lx_q[2];
		mny = (ly_q[0] < ly_q[1]) ? ly_q[0] : ly_q[1];
		mny = (mny < ly_q[2]) ? mny : ly_q[2];
		mxy = (ly_q[0] > ly_q[1]) ? ly_q[0] : ly_q[1];
		mxy = (mxy > ly_q[2]) ? mxy : ly_q[2];
		bx0 = BW'(trz_pkg::trunc_px(mnx));
		bx1 = BW'(trz_pkg::trunc_px(mxx));
		by0 = BW'(trz_pkg::trunc_px(mny));
		by1 = BW'(trz_pkg::trunc_px(mxy));
		if (bx0 < 0) bx0 = '0;
		if (by0 < 0) by0 = '0;
		if (bx1 > XMAX) bx1 = XMAX;
		if (by1 > YMAX) by1 = YMAX;
	end

	always_ff @(posedge clk) begin
		if (cmd.box_en) begin
			mn_x_q  <= bx0[XW-1:0];
			mx_x_q  <= bx1[XW-1:0];
			mn_y_q  <= by0[YW-1:0];
			mx_y_q  <= by1[YW-1:0];
			empty_q <= (bx1 < bx0) || (by1 < by0);
		end
	end

	// Setup operands
	logic signed [SW-1:0] a_u, b_u, a_v, b_v, dx13, dy13, dxs, dys;
	logic signed [SW-1:0] ma, mb;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] p_q [6];

	always_comb begin
		a_u  = SW'(ly_q[1]) - SW'(ly_q[2]);
		b_u  = SW'(lx_q[2]) - SW'(lx_q[1]);
		a_v  = SW'(ly_q[2]) - SW'(ly_q[0]);
		b_v  = SW'(lx_q[0]) - SW'(lx_q[2]);
		dx13 = b_v;
		dy13 = SW'(ly_q[0]) - SW'(ly_q[2]);
		dxs  = $signed(SW'({mn_x_q, 4'b0000})) - SW'(lx_q[2]);
		dys  = $signed(SW'({mn_y_q, 4'b0000})) - SW'(ly_q[2]);
		case (cmd.mul_idx)
			3'd0:    begin ma = a_u; mb = dx13; end
			3'd1:    begin ma = b_u; mb = dy13; end
			3'd2:    begin ma = a_u; mb = dxs;  end
			3'd3:    begin ma = b_u; mb = dys;  end
			3'd4:    begin ma = a_v; mb = dxs;  end
			3'd5:    begin ma = b_v; mb = dys;  end
			default: begin ma = '0;  mb = '0;   end
		endcase
		prod = ma * mb;
	end

	// Shared setup multiplier, one product a cycle
	always_ff @(posedge clk) begin
		if (cmd.mul_en && cmd.mul_idx <= 3'd5) p_q[cmd.mul_idx] <= prod;
	end

	// Area, orientation and edge increments
	logic signed [PW:0]   s01;
	logic signed [EW-1:0] s23, s45, iux, iuy, ivx, ivy;
	logic                 neg;

	always_comb begin
		s01 = (PW+1)'(p_q[0]) + (PW+1)'(p_q[1]);
		neg = s01[PW];
		s23 = EW'(p_q[2]) + EW'(p_q[3]);
		s45 = EW'(p_q[4]) + EW'(p_q[5]);
		iux = EW'(a_u) <<< 4;
		iuy = EW'(b_u) <<< 4;
		ivx = EW'(a_v) <<< 4;
		ivy = EW'(b_v) <<< 4;
	end

	logic [DW-1:0]        d_q;
	logic signed [EW-1:0] nu_q, nv_q, nur_q, nvr_q;
	logic signed [EW-1:0] dux_q, duy_q, dvx_q, dvy_q;
	logic [XW-1:0]        x_q;
	logic [YW-1:0]        y_q;
	logic [AW-1:0]        rowbase_q;
	logic signed [EW-1:0] d_s, nw;
	logic                 x_last, y_last;

	assign d_s    = $signed(EW'(d_q));
	assign nw     = d_s - nu_q - nv_q;
	assign x_last = (x_q == mx_x_q);
	assign y_last = (y_q == mx_y_q);

	// Edge walkers over the box
	always_ff @(posedge clk) begin
		if (cmd.mul_en) rowbase_q <= AW'(mn_y_q * FRAME_WIDTH);
		if (cmd.fin_en) begin
			d_q   <= neg ? DW'(-s01) : DW'(s01);
			nu_q  <= neg ? -s23 : s23;
			nur_q <= neg ? -s23 : s23;
			nv_q  <= neg ? -s45 : s45;
			nvr_q <= neg ? -s45 : s45;
			dux_q <= neg ? -iux : iux;
			duy_q <= neg ? -iuy : iuy;
			dvx_q <= neg ? -ivx : ivx;
			dvy_q <= neg ? -ivy : ivy;
			x_q   <= mn_x_q;
			y_q   <= mn_y_q;
		end else if (cmd.step_en) begin
			if (x_last) begin
				if (!y_last) begin
					x_q       <= mn_x_q;
					y_q       <= y_q + YW'(1);
					rowbase_q <= rowbase_q + AW'(FRAME_WIDTH);
					nur_q     <= nur_q + duy_q;
					nvr_q     <= nvr_q + dvy_q;
					nu_q      <= nur_q + duy_q;
					nv_q      <= nvr_q + dvy_q;
				end
			end else begin
				x_q  <= x_q + XW'(1);
				nu_q <= nu_q + dux_q;
				nv_q <= nv_q + dvx_q;
			end
		end
	end

	// Bit-serial weighted sums, then in-place restoring division
	logic [15:0]      uz [3];
	logic [15:0]      ug [3];
	logic [ACC_W-1:0] tz, tg;
	logic [ACC_W-1:0] accz_q, accg_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uz[i] = {~lz_q[i][15], lz_q[i][14:0]};
			ug[i] = {lg_q[i], 8'h00};
		end
		tz = (uz[0][cmd.bit_idx] ? ACC_W'(nu_q[DW-1:0]) : '0)
			+ (uz[1][cmd.bit_idx] ? ACC_W'(nv_q[DW-1:0]) : '0)
			+ (uz[2][cmd.bit_idx] ? ACC_W'(nw[DW-1:0]) : '0);
		tg = (ug[0][cmd.bit_idx] ? ACC_W'(nu_q[DW-1:0]) : '0)
			+ (ug[1][cmd.bit_idx] ? ACC_W'(nv_q[DW-1:0]) : '0)
			+ (ug[2][cmd.bit_idx] ? ACC_W'(nw[DW-1:0]) : '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_en) begin
			accz_q <= '0;
			accg_q <= '0;
		end else if (cmd.mac_en) begin
			accz_q <= (accz_q << 1) + tz;
			accg_q <= (accg_q << 1) + tg;
		end else if (cmd.div_en) begin
			accz_q <= trz_pkg::div_step(accz_q, d_q);
			accg_q <= trz_pkg::div_step(accg_q, d_q);
		end
	end

	// Frame memory: drawn bit, grey, depth
	logic [trz_pkg::MEM_W-1:0] mem [PIXELS];
	logic [trz_pkg::MEM_W-1:0] rd_q;
	logic [trz_pkg::MEM_W-1:0] wd;
	logic [AW-1:0]             clr_addr_q, pix_addr, rd_addr, wa, rdp_addr;
	logic [AW+7:0]             rd_lin;
	logic                      we, re, in_frame, in_frame_q;
	logic signed [15:0]        zq;

	assign pix_addr = rowbase_q + AW'(x_q);
	assign rd_lin   = (AW+8)'(in_item.pixel_y) * (AW+8)'(FRAME_WIDTH)
			+ (AW+8)'(in_item.pixel_x);
	assign rdp_addr = rd_lin[AW-1:0];
	assign in_frame = (trz_pkg::CMPW'(in_item.pixel_x) < trz_pkg::CMPW'(FRAME_WIDTH))
			&& (trz_pkg::CMPW'(in_item.pixel_y) < trz_pkg::CMPW'(FRAME_HEIGHT));
	assign zq       = $signed({~accz_q[15], accz_q[14:0]});

	always_comb begin
		re      = cmd.rd_req || cmd.pix_en;
		rd_addr = cmd.rd_req ? rdp_addr : pix_addr;
		we      = cmd.clr_en || (cmd.wr_en && (zq < $signed(rd_q[15:0])));
		wa      = cmd.clr_en ? clr_addr_q : pix_addr;
		wd      = cmd.clr_en ? {9'h000, trz_pkg::DEPTH_ONE}
				: {1'b1, accg_q[15:8], zq};
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[rd_addr];
	end

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.rd_req) in_frame_q <= in_frame;
		if (cmd.out_load) begin
			out_item.pixel_color <= (in_frame_q && rd_q[24])
					? {8'hFF, rd_q[23:16], rd_q[23:16], rd_q[23:16]} : 32'h0;
			out_item.pixel_depth <= in_frame_q ? $signed(rd_q[15:0]) : trz_pkg::DEPTH_ONE;
		end
	end

	// Status
	always_comb begin
		sts.clr_last  = (clr_addr_q == AW'(PIXELS - 1));
		sts.d_zero    = (s01 == '0);
		sts.box_empty = empty_q;
		sts.in_tri    = !nu_q[EW-1] && !nv_q[EW-1] && !nw[EW-1];
		sts.x_last    = x_last;
		sts.y_last    = y_last;
	end

endmodule

// ===== rtl/core/triangle_rasterizer_zbuffer.sv =====
// Top level of the triangle rasteriser with depth buffer.
// Instantiates trz_ctrl and trz_dp; types from trz_pkg.
//
//  channel | signals                    | carries
//  --------+----------------------------+------------------------------------
//  in      | in_valid, in_ready, in_item | vertex, clear or read command
//  out     | out_valid, out_ready, out_item | colour and depth of a read pixel
//
// A vertex is latched when accepted; the third also runs setup (box, setup
// products, finish), then each pixel of the clipped box is tested and
// stepped, taking inside the triangle 16 serial multiply-accumulate steps,
// 16 division steps and a write too. A read waits for a free output register;
// a clear sweeps all FRAME_WIDTH * FRAME_HEIGHT entries; reset runs one first.
// in_ready is high only while idle; a finished read waits in the output register.
module triangle_rasterizer_zbuffer #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  trz_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output trz_pkg::out_item_t  out_item
);

	trz_pkg::cmd_t cmd;
	trz_pkg::sts_t sts;

	trz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (in_item.operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	trz_dp #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

	// Only one source writes the frame memory in a cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !cmd.clr_en)
		else $error("pixel write during clearing sweep");

	// The serial units never overlap
	a_units: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_en, cmd.pix_en, cmd.mac_en, cmd.div_en, cmd.step_en}))
		else $error("overlapping datapath commands");

	// A result is loaded only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("read beat overwritten");

endmodule
